@@ design/falru_pkg.sv @@
// ----------------------------------------------------------------------------
// falru_pkg
// Shared types and constants of the fully associative LRU cache directory.
// ----------------------------------------------------------------------------
package falru_pkg;

    localparam int ENTRIES      = 16;
    localparam int OFFSET_WIDTH = 4;
    localparam int IDX_W        = 4;
    localparam int TAG_W        = 32 - OFFSET_WIDTH;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_STORE = 2'd1,
        MODE_FLUSH = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    // command broadcast from the controller to every cell
    typedef struct packed {
        logic             lookup;     // compare tag, latch match
        logic             update;     // apply access to chosen entry
        logic             store;      // access is a store
        logic             flush_clr;  // clean entry at flush_idx
        logic [IDX_W-1:0] flush_idx;
        logic [IDX_W-1:0] sel_idx;    // entry chosen for the access
        logic [IDX_W-1:0] sel_rank;   // rank of chosen entry before update
        logic             miss;
        logic [TAG_W-1:0] tag;
    } cell_cmd_t;

    // state a cell reports back
    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic             match;
        logic [IDX_W-1:0] rank;
        logic [TAG_W-1:0] tag;
    } cell_stat_t;

endpackage

@@ design/falru_cell.sv @@
// ----------------------------------------------------------------------------
// falru_cell
// One directory entry: valid, dirty, tag and recency rank.
// ----------------------------------------------------------------------------
module falru_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [falru_pkg::IDX_W-1:0]    my_idx,
    input  falru_pkg::cell_cmd_t           cmd,
    output falru_pkg::cell_stat_t          stat
);
    import falru_pkg::*;

    logic             valid_reg;
    logic             dirty_reg;
    logic [TAG_W-1:0] tag_reg;
    logic [IDX_W-1:0] rank_reg;
    logic             match_reg;
    logic             chosen;

    assign chosen = (cmd.sel_idx == my_idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            dirty_reg <= 1'b0;
            tag_reg   <= '0;
            rank_reg  <= my_idx;
            match_reg <= 1'b0;
        end
        else
        begin
            if (cmd.lookup)
                match_reg <= valid_reg && (tag_reg == cmd.tag);
            if (cmd.flush_clr && cmd.flush_idx == my_idx)
                dirty_reg <= 1'b0;
            if (cmd.update)
            begin
                if (chosen)
                begin
                    rank_reg <= IDX_W'(ENTRIES - 1);
                    if (cmd.miss)
                    begin
                        valid_reg <= 1'b1;
                        tag_reg   <= cmd.tag;
                    end
                    dirty_reg <= cmd.store || (dirty_reg && !cmd.miss);
                end
                else if (rank_reg > cmd.sel_rank)
                    rank_reg <= rank_reg - 1'b1;
            end
        end
    end

    assign stat = '{valid: valid_reg, dirty: dirty_reg, match: match_reg,
                    rank: rank_reg, tag: tag_reg};
endmodule

@@ design/fully_assoc_lru_cache_directory.sv @@
// ----------------------------------------------------------------------------
// fully_assoc_lru_cache_directory
// Tag directory of a 16-entry fully associative write-back cache, LRU.
// ----------------------------------------------------------------------------
// A load or store gives a single result: the cells compare tags in S_LOOK,
// S_SEL picks the entry and updates every cell's rank, then the registered
// result strobe follows. A flush walks the entries one per cycle, giving a
// result for each dirty entry, or one result with last set if none is dirty.
// busy is high until the state returns to idle: in the cycle of a load or
// store result, or once a flush has walked the last entry. A new start is
// already taken then; results come on done, one cycle each, and cannot be held off.
module fully_assoc_lru_cache_directory (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        mode,
    input  logic [31:0]                       address,
    output logic                              done,
    output logic                              hit,
    output logic [falru_pkg::IDX_W-1:0]       entry_index,
    output logic                              writeback,
    output logic [31:0]                       writeback_address,
    output logic                              fill,
    output logic [31:0]                       fill_address,
    output logic                              misaligned,
    output logic [31:0]                       hit_total,
    output logic [31:0]                       miss_total,
    output logic                              last
);
    import falru_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_LOOK, S_SEL, S_FLUSH} state_t;

    state_t           state_reg;
    logic [1:0]       mode_reg;
    logic [31:0]      addr_reg;
    logic [IDX_W-1:0] fidx_reg;
    logic             fany_reg;
    logic [31:0]      hits_reg, misses_reg;

    cell_cmd_t  cmd;
    cell_stat_t stat [ENTRIES];

    // selection from the cell status
    logic             any_hit, any_inv;
    logic [IDX_W-1:0] hit_idx, inv_idx, lru_idx, sel_idx;
    logic             sel_wb;

    // any dirty entry above index k
    function automatic logic later_dirty(input logic [IDX_W-1:0] k);
        logic r;
        r = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
            if (IDX_W'(i) > k && stat[i].dirty)
                r = 1'b1;
        return r;
    endfunction

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            falru_cell u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .my_idx (IDX_W'(g)),
                .cmd    (cmd),
                .stat   (stat[g])
            );
        end
    endgenerate

    always_comb
    begin
        any_hit = 1'b0;
        any_inv = 1'b0;
        hit_idx = '0;
        inv_idx = '0;
        lru_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (stat[i].match)
            begin
                any_hit = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (!stat[i].valid)
            begin
                any_inv = 1'b1;
                inv_idx = IDX_W'(i);
            end
            if (stat[i].rank == '0)
                lru_idx = IDX_W'(i);
        end
        sel_idx = any_hit ? hit_idx : (any_inv ? inv_idx : lru_idx);
        sel_wb  = !any_hit && stat[sel_idx].valid && stat[sel_idx].dirty;
    end

    always_comb
    begin
        cmd           = '0;
        cmd.tag       = addr_reg[31:OFFSET_WIDTH];
        cmd.sel_idx   = sel_idx;
        cmd.sel_rank  = stat[sel_idx].rank;
        cmd.miss      = !any_hit;
        cmd.store     = (mode_reg == MODE_STORE);
        cmd.flush_idx = fidx_reg;
        cmd.lookup    = (state_reg == S_LOOK);
        cmd.update    = (state_reg == S_SEL);
        cmd.flush_clr = (state_reg == S_FLUSH);
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mode_reg   <= '0;
            addr_reg   <= '0;
            fidx_reg   <= '0;
            fany_reg   <= 1'b0;
            hits_reg   <= '0;
            misses_reg <= '0;
            done       <= 1'b0;
            hit        <= 1'b0;
            entry_index <= '0;
            writeback  <= 1'b0;
            writeback_address <= '0;
            fill       <= 1'b0;
            fill_address <= '0;
            misaligned <= 1'b0;
            hit_total  <= '0;
            miss_total <= '0;
            last       <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        mode_reg <= mode;
                        addr_reg <= address;
                        fidx_reg <= '0;
                        fany_reg <= 1'b0;
                        if (mode == MODE_FLUSH)
                            state_reg <= S_FLUSH;
                        else if (mode != MODE_NONE)
                            state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                    state_reg <= S_SEL;
                S_SEL:
                begin
                    done        <= 1'b1;
                    last        <= 1'b1;
                    hit         <= any_hit;
                    entry_index <= sel_idx;
                    writeback   <= sel_wb;
                    writeback_address <= sel_wb ?
                        {stat[sel_idx].tag, OFFSET_WIDTH'(0)} : 32'd0;
                    fill         <= !any_hit;
                    fill_address <= any_hit ? 32'd0 :
                        {addr_reg[31:OFFSET_WIDTH], OFFSET_WIDTH'(0)};
                    misaligned <= (mode_reg == MODE_LOAD) && (addr_reg[1:0] != 2'b00);
                    if (any_hit)
                    begin
                        if (hits_reg != '1)
                            hits_reg <= hits_reg + 1'b1;
                        hit_total <= (hits_reg != '1) ? hits_reg + 1'b1 : hits_reg;
                        miss_total <= misses_reg;
                    end
                    else
                    begin
                        if (misses_reg != '1)
                            misses_reg <= misses_reg + 1'b1;
                        miss_total <= (misses_reg != '1) ? misses_reg + 1'b1
                                                           : misses_reg;
                        hit_total <= hits_reg;
                    end
                    state_reg <= S_IDLE;
                end
                S_FLUSH:
                begin
                    // find whether a later entry is dirty to mark last
                    if (stat[fidx_reg].dirty)
                    begin
                        done        <= 1'b1;
                        hit         <= 1'b0;
                        entry_index <= fidx_reg;
                        writeback   <= 1'b1;
                        writeback_address <= {stat[fidx_reg].tag, OFFSET_WIDTH'(0)};
                        fill        <= 1'b0;
                        fill_address <= '0;
                        misaligned  <= 1'b0;
                        hit_total   <= hits_reg;
                        miss_total  <= misses_reg;
                        last        <= !later_dirty(fidx_reg);
                        fany_reg    <= 1'b1;
                    end
                    if (fidx_reg == IDX_W'(ENTRIES - 1))
                    begin
                        state_reg <= S_IDLE;
                        if (!fany_reg && !stat[fidx_reg].dirty)
                        begin
                            done        <= 1'b1;
                            hit         <= 1'b0;
                            entry_index <= '0;
                            writeback   <= 1'b0;
                            writeback_address <= '0;
                            fill        <= 1'b0;
                            fill_address <= '0;
                            misaligned  <= 1'b0;
                            hit_total   <= hits_reg;
                            miss_total  <= misses_reg;
                            last        <= 1'b1;
                        end
                    end
                    else
                        fidx_reg <= fidx_reg + 1'b1;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
